### hw/rtl/e2r_pkg.sv
package e2r_pkg;

    // working format: signed, 30 fraction bits
    localparam int WORK_FRAC    = 30;
    localparam int CORDIC_STEPS = 32;
    localparam int CORD_W       = 34;
    localparam int WORD_W       = 32;
    localparam int SUM_W        = 33;
    localparam int NUM_LANES    = 3;

    // gain-compensated 1.0 at 30 fraction bits
    localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sd652032874;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [CORD_W-1:0] cord_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [31:0] atan_turn(input int idx);
        logic signed [31:0] val;
        case (idx)
            0:  val = 32'h20000000;
            1:  val = 32'h12E4051E;
            2:  val = 32'h09FB385B;
            3:  val = 32'h051111D4;
            4:  val = 32'h028B0D43;
            5:  val = 32'h0145D7E1;
            6:  val = 32'h00A2F61E;
            7:  val = 32'h00517C55;
            8:  val = 32'h0028BE53;
            9:  val = 32'h00145F2F;
            10: val = 32'h000A2F98;
            11: val = 32'h000517CC;
            12: val = 32'h00028BE6;
            13: val = 32'h000145F3;
            14: val = 32'h0000A2FA;
            15: val = 32'h0000517D;
            16: val = 32'h000028BE;
            17: val = 32'h0000145F;
            18: val = 32'h00000A30;
            19: val = 32'h00000518;
            20: val = 32'h0000028C;
            21: val = 32'h00000146;
            22: val = 32'h000000A3;
            23: val = 32'h00000051;
            24: val = 32'h00000029;
            25: val = 32'h00000014;
            26: val = 32'h0000000A;
            27: val = 32'h00000005;
            28: val = 32'h00000003;
            29: val = 32'h00000001;
            30: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

    // fixed-point multiply, round half up back to 30 fraction bits
    function automatic word_t fmul(input word_t a, input word_t b);
        logic signed [63:0] prod;
        prod = a * b;
        prod = prod + (64'sd1 <<< (WORK_FRAC - 1));
        return word_t'(prod >>> WORK_FRAC);
    endfunction

endpackage

### hw/rtl/euler_to_rotation_matrix.sv
// Bunge ZXZ Euler angles (phi1, Phi, phi2, fractions of a turn) to the nine
// orientation matrix elements, signed with MATRIX_FRAC_BITS fraction bits and
// saturated to +/-1.0. Fully pipelined: one angle triple is taken per cycle while
// the output is not stalled, and its result passes through 38 register stages
// (one input stage, 32 CORDIC rotation stages, one quadrant stage, two multiply
// stages, a sum stage and a rounding stage). A stalled output freezes the whole
// pipeline.
module euler_to_rotation_matrix #(
    parameter int ANGLE_BITS       = 16,
    parameter int MATRIX_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ANGLE_BITS-1:0]         s_angle_phi1,
    input  logic [ANGLE_BITS-1:0]         s_angle_cap_phi,
    input  logic [ANGLE_BITS-1:0]         s_angle_phi2,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [MATRIX_FRAC_BITS+1:0] m_col1_x,
    output logic signed [MATRIX_FRAC_BITS+1:0] m_col1_y,
    output logic signed [MATRIX_FRAC_BITS+1:0] m_col1_z,
    output logic signed [MATRIX_FRAC_BITS+1:0] m_col2_x,
    output logic signed [MATRIX_FRAC_BITS+1:0] m_col2_y,
    output logic signed [MATRIX_FRAC_BITS+1:0] m_col2_z,
    output logic signed [MATRIX_FRAC_BITS+1:0] m_col3_x,
    output logic signed [MATRIX_FRAC_BITS+1:0] m_col3_y,
    output logic signed [MATRIX_FRAC_BITS+1:0] m_col3_z
);
    import e2r_pkg::*;

    localparam int OUT_W   = MATRIX_FRAC_BITS + 2;
    localparam int SHIFT   = WORK_FRAC - MATRIX_FRAC_BITS;
    localparam int RND_W   = SUM_W + 2;
    localparam int Q_STG   = CORDIC_STEPS + 1;
    localparam int LAST    = Q_STG + 4;
    localparam logic signed [RND_W-1:0] RND_HALF =
        (SHIFT > 0) ? (RND_W'(1) <<< ((SHIFT > 0) ? SHIFT - 1 : 0)) : '0;
    localparam logic signed [RND_W-1:0] LIM = RND_W'(1) <<< MATRIX_FRAC_BITS;

    logic adv;
    logic vld_reg [0:LAST];

    // whole pipeline moves when the output slot is free or being taken
    assign adv     = !vld_reg[LAST] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) vld_reg[k] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k <= LAST; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    // input stage: align angle to 32-bit phase, split quadrant and residual
    logic [ANGLE_BITS-1:0] ang [0:NUM_LANES-1];
    cord_t              cx_reg [0:CORDIC_STEPS][0:NUM_LANES-1];
    cord_t              cy_reg [0:CORDIC_STEPS][0:NUM_LANES-1];
    logic signed [31:0] cz_reg [0:CORDIC_STEPS][0:NUM_LANES-1];
    logic [1:0]         quad_reg [0:CORDIC_STEPS][0:NUM_LANES-1];

    assign ang[0] = s_angle_phi1;
    assign ang[1] = s_angle_cap_phi;
    assign ang[2] = s_angle_phi2;

    always_ff @(posedge aclk) begin
        logic [31:0] phase;
        if (adv) begin
            for (int ln = 0; ln < NUM_LANES; ln++) begin
                phase = 32'(ang[ln]) << (32 - ANGLE_BITS);
                cx_reg[0][ln]   <= CORDIC_X0;
                cy_reg[0][ln]   <= '0;
                cz_reg[0][ln]   <= $signed({2'b00, phase[29:0]});
                quad_reg[0][ln] <= phase[31:30];
            end
        end
    end

    // one CORDIC rotation per stage, three lanes side by side
    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
        localparam logic signed [31:0] ATAN_I = atan_turn(gi);
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int ln = 0; ln < NUM_LANES; ln++) begin
                    quad_reg[gi+1][ln] <= quad_reg[gi][ln];
                    if (!cz_reg[gi][ln][31]) begin
                        cx_reg[gi+1][ln] <= cx_reg[gi][ln] - (cy_reg[gi][ln] >>> gi);
                        cy_reg[gi+1][ln] <= cy_reg[gi][ln] + (cx_reg[gi][ln] >>> gi);
                        cz_reg[gi+1][ln] <= cz_reg[gi][ln] - ATAN_I;
                    end else begin
                        cx_reg[gi+1][ln] <= cx_reg[gi][ln] + (cy_reg[gi][ln] >>> gi);
                        cy_reg[gi+1][ln] <= cy_reg[gi][ln] - (cx_reg[gi][ln] >>> gi);
                        cz_reg[gi+1][ln] <= cz_reg[gi][ln] + ATAN_I;
                    end
                end
            end
        end
    end

    // quadrant rotation to final cosine/sine
    word_t cos_reg [0:NUM_LANES-1];
    word_t sin_reg [0:NUM_LANES-1];

    always_ff @(posedge aclk) begin
        cord_t xv;
        cord_t yv;
        if (adv) begin
            for (int ln = 0; ln < NUM_LANES; ln++) begin
                xv = cx_reg[CORDIC_STEPS][ln];
                yv = cy_reg[CORDIC_STEPS][ln];
                case (quad_reg[CORDIC_STEPS][ln])
                    2'd0: begin
                        cos_reg[ln] <= word_t'(xv);
                        sin_reg[ln] <= word_t'(yv);
                    end
                    2'd1: begin
                        cos_reg[ln] <= word_t'(-yv);
                        sin_reg[ln] <= word_t'(xv);
                    end
                    2'd2: begin
                        cos_reg[ln] <= word_t'(-xv);
                        sin_reg[ln] <= word_t'(-yv);
                    end
                    default: begin
                        cos_reg[ln] <= word_t'(yv);
                        sin_reg[ln] <= word_t'(-xv);
                    end
                endcase
            end
        end
    end

    // first product level
    word_t t_reg, u_reg, c0c1_reg, c2c0_reg, c2s0_reg, s2s1_reg;
    word_t c0s2_reg, s0s2_reg, c2s1_reg, s1s0_reg, s1c0_reg;
    word_t p1_c0_reg, p1_s0_reg, p1_c1_reg, p1_c2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg     <= fmul(sin_reg[2], cos_reg[1]);
            u_reg     <= fmul(cos_reg[1], cos_reg[2]);
            c0c1_reg  <= fmul(cos_reg[0], cos_reg[1]);
            c2c0_reg  <= fmul(cos_reg[2], cos_reg[0]);
            c2s0_reg  <= fmul(cos_reg[2], sin_reg[0]);
            s2s1_reg  <= fmul(sin_reg[2], sin_reg[1]);
            c0s2_reg  <= fmul(cos_reg[0], sin_reg[2]);
            s0s2_reg  <= fmul(sin_reg[0], sin_reg[2]);
            c2s1_reg  <= fmul(cos_reg[2], sin_reg[1]);
            s1s0_reg  <= fmul(sin_reg[1], sin_reg[0]);
            s1c0_reg  <= fmul(sin_reg[1], cos_reg[0]);
            p1_c0_reg <= cos_reg[0];
            p1_s0_reg <= sin_reg[0];
            p1_c1_reg <= cos_reg[1];
            p1_c2_reg <= cos_reg[2];
        end
    end

    // second product level
    word_t ts0_reg, tc0_reg, us0_reg, ccc_reg;
    word_t p2_c2c0_reg, p2_c2s0_reg, p2_s2s1_reg, p2_c0s2_reg, p2_s0s2_reg;
    word_t p2_c2s1_reg, p2_s1s0_reg, p2_s1c0_reg, p2_c1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ts0_reg     <= fmul(t_reg, p1_s0_reg);
            tc0_reg     <= fmul(t_reg, p1_c0_reg);
            us0_reg     <= fmul(u_reg, p1_s0_reg);
            ccc_reg     <= fmul(c0c1_reg, p1_c2_reg);
            p2_c2c0_reg <= c2c0_reg;
            p2_c2s0_reg <= c2s0_reg;
            p2_s2s1_reg <= s2s1_reg;
            p2_c0s2_reg <= c0s2_reg;
            p2_s0s2_reg <= s0s2_reg;
            p2_c2s1_reg <= c2s1_reg;
            p2_s1s0_reg <= s1s0_reg;
            p2_s1c0_reg <= s1c0_reg;
            p2_c1_reg   <= p1_c1_reg;
        end
    end

    // element sums at working precision
    sum_t el_reg [0:8];

    always_ff @(posedge aclk) begin
        if (adv) begin
            el_reg[0] <= sum_t'(p2_c2c0_reg) - sum_t'(ts0_reg);
            el_reg[1] <= sum_t'(p2_c2s0_reg) + sum_t'(tc0_reg);
            el_reg[2] <= sum_t'(p2_s2s1_reg);
            el_reg[3] <= -sum_t'(p2_c0s2_reg) - sum_t'(us0_reg);
            el_reg[4] <= sum_t'(ccc_reg) - sum_t'(p2_s0s2_reg);
            el_reg[5] <= sum_t'(p2_c2s1_reg);
            el_reg[6] <= sum_t'(p2_s1s0_reg);
            el_reg[7] <= -sum_t'(p2_s1c0_reg);
            el_reg[8] <= sum_t'(p2_c1_reg);
        end
    end

    // round to output precision and saturate to +/-1.0
    logic signed [OUT_W-1:0] out_reg [0:8];

    always_ff @(posedge aclk) begin
        logic signed [RND_W-1:0] rv;
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                rv = (RND_W'(el_reg[k]) + RND_HALF) >>> SHIFT;
                if (rv > LIM) begin
                    out_reg[k] <= OUT_W'(LIM);
                end else if (rv < -LIM) begin
                    out_reg[k] <= OUT_W'(-LIM);
                end else begin
                    out_reg[k] <= OUT_W'(rv);
                end
            end
        end
    end

    assign m_col1_x = out_reg[0];
    assign m_col1_y = out_reg[1];
    assign m_col1_z = out_reg[2];
    assign m_col2_x = out_reg[3];
    assign m_col2_y = out_reg[4];
    assign m_col2_z = out_reg[5];
    assign m_col3_x = out_reg[6];
    assign m_col3_y = out_reg[7];
    assign m_col3_z = out_reg[8];

    // checks
    a_range_c1x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (RND_W'(m_col1_x) <= LIM) && (RND_W'(m_col1_x) >= -LIM))
        else $error("col1_x out of range");

    a_range_c3z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (RND_W'(m_col3_z) <= LIM) && (RND_W'(m_col3_z) >= -LIM))
        else $error("col3_z out of range");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_col2_y))
        else $error("stalled transfer changed");

endmodule

### tb/tb_top.sv
module tb_top;
    import e2r_pkg::*;

    localparam int ANG_W   = 16;
    localparam int OUT_FR  = 14;
    localparam int OUT_W   = OUT_FR + 2;
    localparam int LATENCY = 38;
    localparam int N_RAND  = 1150;

    typedef logic signed [OUT_W-1:0] elem_t;

    typedef struct {
        elem_t c1x, c1y, c1z, c2x, c2y, c2z, c3x, c3y, c3z;
    } orient_t;

    typedef struct {
        logic [ANG_W-1:0] phi1, cap_phi, phi2;
        bit               typed;   // expected matrix typed into the table
        orient_t          mat;
    } angle_row_t;

    // atan(2^-i) in 2^-32 turn
    localparam longint ATAN_TURN [32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001, 64'h00000000
    };

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic [ANG_W-1:0] s_angle_phi1, s_angle_cap_phi, s_angle_phi2;
    elem_t m_col1_x, m_col1_y, m_col1_z, m_col2_x, m_col2_y, m_col2_z;
    elem_t m_col3_x, m_col3_y, m_col3_z;

    orient_t    matrix_q[$];
    angle_row_t dir_rows[$];
    int         err_cnt = 0;

    euler_to_rotation_matrix #(.ANGLE_BITS(ANG_W), .MATRIX_FRAC_BITS(OUT_FR)) dut (.*);

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    // CORDIC sine and cosine of a turn fraction, 30 fraction bits
    task automatic turn_sincos(input logic [ANG_W-1:0] ang, output longint c,
                               output longint s);
        logic [31:0] phase;
        longint x, y, z, dx, dy;
        phase = {ang, {(32-ANG_W){1'b0}}};
        x = 652032874;
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TURN[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TURN[i];
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // round 30 -> 14 fraction bits, saturate to +/-1.0
    function automatic elem_t to_elem(longint v);
        longint r;
        r = (v + (64'sd1 <<< (29 - OUT_FR))) >>> (30 - OUT_FR);
        if (r > (64'sd1 <<< OUT_FR)) r = 64'sd1 <<< OUT_FR;
        if (r < -(64'sd1 <<< OUT_FR)) r = -(64'sd1 <<< OUT_FR);
        return elem_t'(r);
    endfunction

    task automatic predict_matrix(input angle_row_t a, output orient_t m);
        longint c0, s0, c1, s1, c2, s2, t, u;
        turn_sincos(a.phi1, c0, s0);
        turn_sincos(a.cap_phi, c1, s1);
        turn_sincos(a.phi2, c2, s2);
        t = qmul(s2, c1);
        u = qmul(c1, c2);
        m.c1x = to_elem(qmul(c2, c0) - qmul(t, s0));
        m.c1y = to_elem(qmul(c2, s0) + qmul(t, c0));
        m.c1z = to_elem(qmul(s2, s1));
        m.c2x = to_elem(-qmul(c0, s2) - qmul(u, s0));
        m.c2y = to_elem(qmul(qmul(c0, c1), c2) - qmul(s0, s2));
        m.c2z = to_elem(qmul(c2, s1));
        m.c3x = to_elem(qmul(s1, s0));
        m.c3y = to_elem(-qmul(s1, c0));
        m.c3z = to_elem(c1);
    endtask

    function automatic logic [ANG_W-1:0] rand_angle();
        logic [ANG_W-1:0] base;
        // mostly uniform, some near the quadrant edges
        if ($urandom_range(0, 4) != 0) return ANG_W'($urandom);
        base = ANG_W'($urandom_range(0, 3)) << (ANG_W - 2);
        return base + ANG_W'($urandom_range(0, 8)) - ANG_W'(4);
    endfunction

    function automatic void add_row(logic [ANG_W-1:0] p1, logic [ANG_W-1:0] cp,
                                    logic [ANG_W-1:0] p2);
        angle_row_t r;
        r.phi1 = p1; r.cap_phi = cp; r.phi2 = p2; r.typed = 1'b0;
        dir_rows.push_back(r);
    endfunction

    task automatic check_elem(string nm, elem_t want, elem_t got);
        if (want !== got) begin
            $display("%0t %s expected %0d actual %0d", $time, nm, want, got);
            err_cnt++;
        end
    endtask

    // result side: compare each transfer against the oldest expectation
    always @(posedge aclk) begin
        orient_t e;
        if (aresetn && m_valid && m_ready) begin
            if (matrix_q.size() == 0) begin
                $display("%0t unexpected result transfer", $time);
                err_cnt++;
            end else begin
                e = matrix_q.pop_front();
                check_elem("col1_x", e.c1x, m_col1_x);
                check_elem("col1_y", e.c1y, m_col1_y);
                check_elem("col1_z", e.c1z, m_col1_z);
                check_elem("col2_x", e.c2x, m_col2_x);
                check_elem("col2_y", e.c2y, m_col2_y);
                check_elem("col2_z", e.c2z, m_col2_z);
                check_elem("col3_x", e.c3x, m_col3_x);
                check_elem("col3_y", e.c3y, m_col3_y);
                check_elem("col3_z", e.c3z, m_col3_z);
            end
        end
    end

    // receiver stall pattern: one of four modes, redrawn at random during the run
    int unsigned rx_cyc = 0;
    int unsigned rx_mode = 0;
    always @(negedge aclk) begin
        if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
        rx_cyc++;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (rx_cyc % 5 == 0);
            default: m_ready <= (rx_cyc % 32) > 20;
        endcase
    end

    initial begin
        #(12 * 400000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus
    initial begin
        angle_row_t row;
        orient_t    exp_m;
        int         burst, gap, n_items;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_angle_phi1 = '0; s_angle_cap_phi = '0; s_angle_phi2 = '0;

        // zero angles give the identity
        row.phi1 = '0; row.cap_phi = '0; row.phi2 = '0; row.typed = 1'b1;
        row.mat = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        dir_rows.push_back(row);
        add_row(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_row(16'h4000, 16'h0000, 16'h0000);
        add_row(16'h0000, 16'h4000, 16'h0000);
        add_row(16'h0000, 16'h0000, 16'h4000);
        add_row(16'h8000, 16'h8000, 16'h8000);
        add_row(16'hC000, 16'hC000, 16'hC000);
        add_row(16'h3FFF, 16'h7FFF, 16'hBFFF);
        add_row(16'h0001, 16'h4001, 16'h8001);
        add_row(16'hAAAA, 16'h5555, 16'hAAAA);
        add_row(16'h5555, 16'hAAAA, 16'h5555);
        add_row(16'h2000, 16'h6000, 16'hE000);
        add_row(16'hFFFF, 16'h0000, 16'h0001);
        add_row(16'h1234, 16'h8000, 16'hFEDC);

        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        n_items = dir_rows.size() + N_RAND;
        burst = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i < dir_rows.size()) begin
                row = dir_rows[i];
            end else begin
                row.phi1 = rand_angle(); row.cap_phi = rand_angle();
                row.phi2 = rand_angle(); row.typed = 1'b0;
            end
            // bursts of random length separated by random gaps
            gap = 0;
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            burst--;
            while (gap > 0) begin
                @(negedge aclk) s_valid = 1'b0;
                gap--;
            end
            @(negedge aclk);
            s_valid = 1'b1;
            s_angle_phi1 = row.phi1;
            s_angle_cap_phi = row.cap_phi;
            s_angle_phi2 = row.phi2;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            if (row.typed) exp_m = row.mat;
            else predict_matrix(row, exp_m);
            matrix_q.push_back(exp_m);
        end
        @(negedge aclk) s_valid = 1'b0;

        wait (matrix_q.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### euler_to_rotation_matrix.f
hw/rtl/e2r_pkg.sv
hw/rtl/euler_to_rotation_matrix.sv
tb/tb_top.sv
